### rtl/core/mae_pkg.sv
package mae_pkg;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ILLEGAL = 2'd1;
    localparam logic [1:0] ST_UNDEF   = 2'd2;

    localparam logic [3:0] OP_MUL   = 4'd0;
    localparam logic [3:0] OP_MLA   = 4'd1;
    localparam logic [3:0] OP_UMULL = 4'd4;
    localparam logic [3:0] OP_UMLAL = 4'd5;
    localparam logic [3:0] OP_SMULL = 4'd6;
    localparam logic [3:0] OP_SMLAL = 4'd7;

    localparam logic [3:0] REG_PC = 4'd15;

    typedef struct packed {
        logic [1:0]  status;
        logic        wide;
        logic        sgn;
        logic        accum;
        logic        sbit;
        logic [3:0]  rd_idx;
        logic [3:0]  rn_idx;
        logic [31:0] rm_value;
        logic [31:0] rs_value;
        logic [31:0] rn_value;
        logic [31:0] rd_value;
    } t_item;

    typedef struct packed {
        logic [1:0] status;
        logic       wide;
        logic       sbit;
        logic [3:0] rd_idx;
        logic [3:0] rn_idx;
    } t_ctl;

endpackage

### rtl/core/multiply_accumulate_execute.sv
// A result passes the queue write at the transfer edge, then the multiply stage, then the
// accumulate and output register, where an output stall holds it until it is taken.
// Throughput: one instruction per cycle while the output is not stalled; the 33x33 multiply and
// the 64-bit add are each one pipeline stage.
// Reset (i_rst_n low, synchronous): empties the queue and both back-end stages.
module multiply_accumulate_execute #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_instruction_word,
    input  logic [31:0] i_rm_value,
    input  logic [31:0] i_rs_value,
    input  logic [31:0] i_rn_value,
    input  logic [31:0] i_rd_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic        o_main_write,
    output logic [3:0]  o_main_index,
    output logic [31:0] o_main_value,
    output logic        o_low_write,
    output logic [3:0]  o_low_index,
    output logic [31:0] o_low_value,
    output logic        o_flags_write,
    output logic        o_negative_flag,
    output logic        o_zero_flag
);
    import mae_pkg::*;

    t_item dec_item;
    t_item q_item;
    logic  q_full;
    logic  q_empty;
    logic  q_pop;

    assign o_stall = q_full;

    mae_front u_front (
        .i_instruction_word (i_instruction_word),
        .i_rm_value         (i_rm_value),
        .i_rs_value         (i_rs_value),
        .i_rn_value         (i_rn_value),
        .i_rd_value         (i_rd_value),
        .o_item             (dec_item)
    );

    mae_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_item  (dec_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    mae_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (q_empty),
        .i_item          (q_item),
        .o_pop           (q_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_main_write    (o_main_write),
        .o_main_index    (o_main_index),
        .o_main_value    (o_main_value),
        .o_low_write     (o_low_write),
        .o_low_index     (o_low_index),
        .o_low_value     (o_low_value),
        .o_flags_write   (o_flags_write),
        .o_negative_flag (o_negative_flag),
        .o_zero_flag     (o_zero_flag)
    );

endmodule

### rtl/core/mae_front.sv
module mae_front (
    input  logic [31:0]   i_instruction_word,
    input  logic [31:0]   i_rm_value,
    input  logic [31:0]   i_rs_value,
    input  logic [31:0]   i_rn_value,
    input  logic [31:0]   i_rd_value,
    output mae_pkg::t_item o_item
);
    import mae_pkg::*;

    logic [3:0] op;
    logic [3:0] rd;
    logic [3:0] rn;
    logic [3:0] rs;
    logic [3:0] rm;
    logic       defined;
    logic       wide;
    logic       sgn;
    logic       accum;
    logic       illegal;

    assign op = i_instruction_word[24:21];
    assign rd = i_instruction_word[19:16];
    assign rn = i_instruction_word[15:12];
    assign rs = i_instruction_word[11:8];
    assign rm = i_instruction_word[3:0];

    always_comb begin
        defined = 1'b1;
        wide    = 1'b0;
        sgn     = 1'b0;
        accum   = 1'b0;
        case (op)
            OP_MUL: begin
            end
            OP_MLA: begin
                accum = 1'b1;
            end
            OP_UMULL: begin
                wide = 1'b1;
            end
            OP_UMLAL: begin
                wide  = 1'b1;
                accum = 1'b1;
            end
            OP_SMULL: begin
                wide = 1'b1;
                sgn  = 1'b1;
            end
            OP_SMLAL: begin
                wide  = 1'b1;
                sgn   = 1'b1;
                accum = 1'b1;
            end
            default: begin
                defined = 1'b0;
            end
        endcase
    end

    assign illegal = (rd == REG_PC) || (rn == REG_PC) || (rs == REG_PC) || (rm == REG_PC)
                   || (rd == rm) || (wide && ((rd == rn) || (rn == rm)));

    always_comb begin
        o_item.status   = !defined ? ST_UNDEF : (illegal ? ST_ILLEGAL : ST_OK);
        o_item.wide     = wide;
        o_item.sgn      = sgn;
        o_item.accum    = accum;
        o_item.sbit     = i_instruction_word[20];
        o_item.rd_idx   = rd;
        o_item.rn_idx   = rn;
        o_item.rm_value = i_rm_value;
        o_item.rs_value = i_rs_value;
        o_item.rn_value = i_rn_value;
        o_item.rd_value = i_rd_value;
    end

endmodule

### rtl/core/mae_queue.sv
module mae_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mae_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output mae_pkg::t_item o_item
);
    import mae_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_item         r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_wr_ptr;
    logic [AW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;
    logic          push_ok;
    logic          pop_ok;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### rtl/core/mae_back.sv
module mae_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  mae_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [1:0]     o_status,
    output logic           o_main_write,
    output logic [3:0]     o_main_index,
    output logic [31:0]    o_main_value,
    output logic           o_low_write,
    output logic [3:0]     o_low_index,
    output logic [31:0]    o_low_value,
    output logic           o_flags_write,
    output logic           o_negative_flag,
    output logic           o_zero_flag
);
    import mae_pkg::*;

    logic               r1_valid;
    t_ctl               r1_ctl;
    logic [63:0]        r1_prod;
    logic [63:0]        r1_addend;
    logic               r2_valid;
    logic [1:0]         r2_status;
    logic               r2_main_write;
    logic [3:0]         r2_main_index;
    logic [31:0]        r2_main_value;
    logic               r2_low_write;
    logic [3:0]         r2_low_index;
    logic [31:0]        r2_low_value;
    logic               r2_flags_write;
    logic               r2_negative;
    logic               r2_zero;

    logic               s2_load;
    logic               s1_load;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;
    logic [63:0]        n_addend;
    logic [63:0]        sum;
    logic               ok;
    logic               neg;
    logic               zer;

    assign s2_load = !r2_valid || !i_stall;
    assign s1_load = !r1_valid || s2_load;
    assign o_pop   = s1_load && !i_empty;

    assign mul_a = $signed({i_item.sgn & i_item.rm_value[31], i_item.rm_value});
    assign mul_b = $signed({i_item.sgn & i_item.rs_value[31], i_item.rs_value});
    assign mul_p = mul_a * mul_b;

    always_comb begin
        n_addend = '0;
        if (i_item.accum) begin
            n_addend = i_item.wide ? {i_item.rd_value, i_item.rn_value}
                                   : {32'd0, i_item.rn_value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (s1_load) begin
            r1_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r1_ctl.status <= i_item.status;
            r1_ctl.wide   <= i_item.wide;
            r1_ctl.sbit   <= i_item.sbit;
            r1_ctl.rd_idx <= i_item.rd_idx;
            r1_ctl.rn_idx <= i_item.rn_idx;
            r1_prod       <= mul_p[63:0];
            r1_addend     <= n_addend;
        end
    end

    assign sum = r1_prod + r1_addend;
    assign ok  = (r1_ctl.status == ST_OK);
    assign neg = r1_ctl.wide ? sum[63] : sum[31];
    assign zer = r1_ctl.wide ? (sum == 64'd0) : (sum[31:0] == 32'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (s2_load) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load && r1_valid) begin
            r2_status      <= r1_ctl.status;
            r2_main_write  <= ok;
            r2_main_index  <= ok ? r1_ctl.rd_idx : 4'd0;
            r2_main_value  <= !ok ? 32'd0 : (r1_ctl.wide ? sum[63:32] : sum[31:0]);
            r2_low_write   <= ok && r1_ctl.wide;
            r2_low_index   <= (ok && r1_ctl.wide) ? r1_ctl.rn_idx : 4'd0;
            r2_low_value   <= (ok && r1_ctl.wide) ? sum[31:0] : 32'd0;
            r2_flags_write <= ok && r1_ctl.sbit;
            r2_negative    <= ok && r1_ctl.sbit && neg;
            r2_zero        <= ok && r1_ctl.sbit && zer;
        end
    end

    assign o_valid         = r2_valid;
    assign o_status        = r2_status;
    assign o_main_write    = r2_main_write;
    assign o_main_index    = r2_main_index;
    assign o_main_value    = r2_main_value;
    assign o_low_write     = r2_low_write;
    assign o_low_index     = r2_low_index;
    assign o_low_value     = r2_low_value;
    assign o_flags_write   = r2_flags_write;
    assign o_negative_flag = r2_negative;
    assign o_zero_flag     = r2_zero;

endmodule

### tb/tb_multiply_accumulate_execute.sv
module tb_multiply_accumulate_execute;
    timeunit 1ns;
    timeprecision 1ps;

    import mae_pkg::*;

    localparam logic [3:0]  OP_RSVD_2  = 4'd2;
    localparam logic [3:0]  OP_RSVD_3  = 4'd3;
    localparam logic [3:0]  OP_RSVD_8  = 4'd8;
    localparam logic [3:0]  OP_RSVD_15 = 4'd15;
    localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
    localparam logic [31:0] MIN_NEG    = 32'h8000_0000;
    localparam logic [31:0] MAX_POS    = 32'h7FFF_FFFF;
    localparam logic [31:0] FREE_BITS  = 32'hFE00_00F0;
    localparam int          RANDOM_OPS = 1527;
    localparam int          CALM_TAIL  = 150;
    localparam int          HOLD_AT    = 300;
    localparam int          HOLD_LEN   = 64;

    typedef struct packed {
        logic [1:0]  status;
        logic        main_write;
        logic [3:0]  main_index;
        logic [31:0] main_value;
        logic        low_write;
        logic [3:0]  low_index;
        logic [31:0] low_value;
        logic        flags_write;
        logic        negative_flag;
        logic        zero_flag;
    } mac_result_t;

    typedef struct {
        logic [31:0] word;
        logic [31:0] rm_v;
        logic [31:0] rs_v;
        logic [31:0] rn_v;
        logic [31:0] rd_v;
        bit          typed;
        mac_result_t want;
    } mac_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_instruction_word;
    logic [31:0] i_rm_value;
    logic [31:0] i_rs_value;
    logic [31:0] i_rn_value;
    logic [31:0] i_rd_value;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_status;
    logic        o_main_write;
    logic [3:0]  o_main_index;
    logic [31:0] o_main_value;
    logic        o_low_write;
    logic [3:0]  o_low_index;
    logic [31:0] o_low_value;
    logic        o_flags_write;
    logic        o_negative_flag;
    logic        o_zero_flag;

    mac_result_t pending_results[$];
    mac_row_t    dir_rows[$];
    mac_result_t head;
    int          n_fail;
    int          n_sent;
    bit          quiet;
    bit          held;
    int unsigned tx_odds;
    int unsigned rx_odds;
    int unsigned rx_tick;

    multiply_accumulate_execute dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_instruction_word (i_instruction_word),
        .i_rm_value         (i_rm_value),
        .i_rs_value         (i_rs_value),
        .i_rn_value         (i_rn_value),
        .i_rd_value         (i_rd_value),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_status           (o_status),
        .o_main_write       (o_main_write),
        .o_main_index       (o_main_index),
        .o_main_value       (o_main_value),
        .o_low_write        (o_low_write),
        .o_low_index        (o_low_index),
        .o_low_value        (o_low_value),
        .o_flags_write      (o_flags_write),
        .o_negative_flag    (o_negative_flag),
        .o_zero_flag        (o_zero_flag)
    );

    function automatic logic [31:0] mac_word(input logic [3:0] op, input logic s,
                                             input logic [3:0] rd, rn, rs, rm);
        return {7'd0, op, s, rd, rn, rs, 4'd0, rm};
    endfunction

    function automatic mac_result_t status_only(input logic [1:0] st);
        mac_result_t r;
        r = '0;
        r.status = st;
        return r;
    endfunction

    function automatic mac_result_t mac_compute(input logic [31:0] word, rm_v, rs_v, rn_v,
                                                rd_v);
        mac_result_t r;
        logic [3:0]  op;
        logic [3:0]  rd;
        logic [3:0]  rn;
        logic [3:0]  rs;
        logic [3:0]  rm;
        logic        wide;
        logic        neg;
        logic        zer;
        logic [31:0] sum32;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] sum64;
        r = '0;
        op = word[24:21];
        rd = word[19:16];
        rn = word[15:12];
        rs = word[11:8];
        rm = word[3:0];
        case (op)
            OP_MUL, OP_MLA: wide = 1'b0;
            OP_UMULL, OP_UMLAL, OP_SMULL, OP_SMLAL: wide = 1'b1;
            default: begin
                r.status = ST_UNDEF;
                return r;
            end
        endcase
        if (rd == REG_PC || rn == REG_PC || rs == REG_PC || rm == REG_PC || rd == rm ||
            (wide && (rd == rn || rn == rm))) begin
            r.status = ST_ILLEGAL;
            return r;
        end
        r.status = ST_OK;
        r.main_write = 1'b1;
        r.main_index = rd;
        if (!wide) begin
            sum32 = rm_v * rs_v;
            if (op == OP_MLA) begin
                sum32 = sum32 + rn_v;
            end
            r.main_value = sum32;
            neg = sum32[31];
            zer = (sum32 == 32'd0);
        end else begin
            if (op == OP_SMULL || op == OP_SMLAL) begin
                a = {{32{rm_v[31]}}, rm_v};
                b = {{32{rs_v[31]}}, rs_v};
            end else begin
                a = {32'd0, rm_v};
                b = {32'd0, rs_v};
            end
            sum64 = a * b;
            if (op == OP_UMLAL || op == OP_SMLAL) begin
                sum64 = sum64 + {rd_v, rn_v};
            end
            r.main_value = sum64[63:32];
            r.low_write = 1'b1;
            r.low_index = rn;
            r.low_value = sum64[31:0];
            neg = sum64[63];
            zer = (sum64 == 64'd0);
        end
        if (word[20]) begin
            r.flags_write = 1'b1;
            r.negative_flag = neg;
            r.zero_flag = zer;
        end
        return r;
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return ALL_ONES;
            2: return MIN_NEG;
            3: return MAX_POS;
            4: return 32'($urandom_range(0, 255));
            5: return ~32'($urandom_range(0, 255));
            default: return 32'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] random_word();
        int unsigned kind;
        logic [3:0]  op;
        logic [3:0]  rd;
        logic [3:0]  rn;
        logic [3:0]  rs;
        logic [3:0]  rm;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            return 32'($urandom);
        end
        case ($urandom_range(0, 5))
            0: op = OP_MUL;
            1: op = OP_MLA;
            2: op = OP_UMULL;
            3: op = OP_UMLAL;
            4: op = OP_SMULL;
            default: op = OP_SMLAL;
        endcase
        if (kind == 1) begin
            rd = 4'($urandom);
            rn = 4'($urandom);
            rs = 4'($urandom);
            rm = 4'($urandom);
        end else begin
            rs = 4'($urandom_range(0, 14));
            do begin
                rd = 4'($urandom_range(0, 14));
                rn = 4'($urandom_range(0, 14));
                rm = 4'($urandom_range(0, 14));
            end while (rd == rm || (op[2] && (rd == rn || rn == rm)));
        end
        return mac_word(op, 1'($urandom), rd, rn, rs, rm) | (32'($urandom) & FREE_BITS);
    endfunction

    task automatic add_row(input logic [31:0] word, rm_v, rs_v, rn_v, rd_v, input bit typed,
                           input mac_result_t want);
        dir_rows.push_back('{word, rm_v, rs_v, rn_v, rd_v, typed, want});
    endtask

    task automatic send_item(input logic [31:0] word, rm_v, rs_v, rn_v, rd_v,
                             input mac_result_t want);
        int unsigned gap;
        i_valid <= 1'b1;
        i_instruction_word <= word;
        i_rm_value <= rm_v;
        i_rs_value <= rs_v;
        i_rn_value <= rn_v;
        i_rd_value <= rd_v;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(want);
        n_sent++;
        gap = (!quiet && $urandom_range(0, 99) < tx_odds) ? $urandom_range(1, 5) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want, got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            n_fail++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("multiply_accumulate_execute: mismatch");
        $finish;
    end

    initial begin
        i_stall <= 1'b0;
        rx_odds = 20;
        rx_tick = 0;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            rx_tick++;
            if (rx_tick % 64 == 0) begin
                rx_odds = $urandom_range(0, 3) * 10;
            end
            if (!held && n_sent >= HOLD_AT) begin
                held = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < rx_odds) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected transfer: status %0d main_value %0h", o_status,
                       o_main_value);
                n_fail++;
            end else begin
                head = pending_results.pop_front();
                check_field("status", 32'(head.status), 32'(o_status));
                check_field("main_write", 32'(head.main_write), 32'(o_main_write));
                check_field("main_index", 32'(head.main_index), 32'(o_main_index));
                check_field("main_value", head.main_value, o_main_value);
                check_field("low_write", 32'(head.low_write), 32'(o_low_write));
                check_field("low_index", 32'(head.low_index), 32'(o_low_index));
                check_field("low_value", head.low_value, o_low_value);
                check_field("flags_write", 32'(head.flags_write), 32'(o_flags_write));
                check_field("negative_flag", 32'(head.negative_flag), 32'(o_negative_flag));
                check_field("zero_flag", 32'(head.zero_flag), 32'(o_zero_flag));
            end
        end
    end

    initial begin
        logic [31:0] word;
        logic [31:0] rm_v;
        logic [31:0] rs_v;
        logic [31:0] rn_v;
        logic [31:0] rd_v;
        n_fail = 0;
        n_sent = 0;
        quiet = 1'b0;
        tx_odds = 20;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_instruction_word <= '0;
        i_rm_value <= '0;
        i_rs_value <= '0;
        i_rn_value <= '0;
        i_rd_value <= '0;

        add_row(mac_word(OP_MUL, 1'b1, 4'd1, 4'd0, 4'd2, 4'd3), 32'd0, 32'd0, 32'd0, 32'd0,
                1'b1, '{ST_OK, 1'b1, 4'd1, 32'd0, 1'b0, 4'd0, 32'd0, 1'b1, 1'b0, 1'b1});
        add_row(mac_word(OP_MUL, 1'b1, 4'd1, 4'd0, 4'd2, 4'd3), ALL_ONES, ALL_ONES, 32'd0,
                32'd0, 1'b1, '{ST_OK, 1'b1, 4'd1, 32'd1, 1'b0, 4'd0, 32'd0, 1'b1, 1'b0, 1'b0});
        add_row(mac_word(OP_MLA, 1'b1, 4'd2, 4'd3, 4'd4, 4'd5), ALL_ONES, 32'd1, 32'd1, 32'd0,
                1'b0, '0);
        add_row(mac_word(OP_MLA, 1'b0, 4'd2, 4'd3, 4'd4, 4'd5), MAX_POS, 32'd2, MIN_NEG, 32'd0,
                1'b0, '0);
        add_row(mac_word(OP_MLA, 1'b1, 4'd4, 4'd4, 4'd5, 4'd6), 32'd3, 32'd5, 32'd7, 32'd0,
                1'b0, '0);
        add_row(mac_word(OP_UMULL, 1'b1, 4'd7, 4'd8, 4'd9, 4'd10), ALL_ONES, ALL_ONES, 32'd0,
                32'd0, 1'b0, '0);
        add_row(mac_word(OP_UMLAL, 1'b1, 4'd7, 4'd8, 4'd9, 4'd10), ALL_ONES, ALL_ONES,
                ALL_ONES, ALL_ONES, 1'b0, '0);
        add_row(mac_word(OP_SMULL, 1'b1, 4'd11, 4'd12, 4'd13, 4'd14), MIN_NEG, MIN_NEG, 32'd0,
                32'd0, 1'b0, '0);
        add_row(mac_word(OP_SMULL, 1'b1, 4'd0, 4'd1, 4'd2, 4'd3), ALL_ONES, 32'd1, 32'd0,
                32'd0, 1'b0, '0);
        add_row(mac_word(OP_SMLAL, 1'b1, 4'd0, 4'd1, 4'd2, 4'd3), ALL_ONES, 32'd1, 32'd1,
                32'd0, 1'b0, '0);
        add_row(mac_word(OP_UMULL, 1'b0, 4'd14, 4'd13, 4'd12, 4'd11), 32'd0, ALL_ONES,
                ALL_ONES, ALL_ONES, 1'b0, '0);
        add_row(mac_word(OP_SMLAL, 1'b0, 4'd5, 4'd6, 4'd6, 4'd7), MAX_POS, MAX_POS, ALL_ONES,
                MAX_POS, 1'b0, '0);
        add_row(mac_word(OP_RSVD_2, 1'b1, 4'd1, 4'd2, 4'd3, 4'd4), ALL_ONES, ALL_ONES,
                ALL_ONES, ALL_ONES, 1'b1, status_only(ST_UNDEF));
        add_row(mac_word(OP_RSVD_3, 1'b0, 4'd15, 4'd2, 4'd3, 4'd4), 32'd1, 32'd1, 32'd1,
                32'd1, 1'b1, status_only(ST_UNDEF));
        add_row(mac_word(OP_RSVD_8, 1'b1, 4'd1, 4'd2, 4'd3, 4'd1), 32'd5, 32'd5, 32'd5, 32'd5,
                1'b1, status_only(ST_UNDEF));
        add_row(ALL_ONES | mac_word(OP_RSVD_15, 1'b1, 4'd15, 4'd15, 4'd15, 4'd15), ALL_ONES,
                ALL_ONES, ALL_ONES, ALL_ONES, 1'b1, status_only(ST_UNDEF));
        add_row(mac_word(OP_MUL, 1'b1, 4'd15, 4'd0, 4'd2, 4'd3), 32'd2, 32'd3, 32'd0, 32'd0,
                1'b1, status_only(ST_ILLEGAL));
        add_row(mac_word(OP_MUL, 1'b1, 4'd1, 4'd15, 4'd2, 4'd3), 32'd2, 32'd3, 32'd0, 32'd0,
                1'b1, status_only(ST_ILLEGAL));
        add_row(mac_word(OP_MLA, 1'b0, 4'd1, 4'd0, 4'd15, 4'd3), 32'd2, 32'd3, 32'd4, 32'd0,
                1'b1, status_only(ST_ILLEGAL));
        add_row(mac_word(OP_UMULL, 1'b1, 4'd1, 4'd2, 4'd3, 4'd15), 32'd2, 32'd3, 32'd0, 32'd0,
                1'b1, status_only(ST_ILLEGAL));
        add_row(mac_word(OP_MUL, 1'b1, 4'd6, 4'd0, 4'd2, 4'd6), 32'd2, 32'd3, 32'd0, 32'd0,
                1'b1, status_only(ST_ILLEGAL));
        add_row(mac_word(OP_UMLAL, 1'b1, 4'd6, 4'd6, 4'd2, 4'd3), 32'd2, 32'd3, 32'd4, 32'd5,
                1'b1, status_only(ST_ILLEGAL));
        add_row(mac_word(OP_SMLAL, 1'b0, 4'd6, 4'd3, 4'd2, 4'd3), 32'd2, 32'd3, 32'd4, 32'd5,
                1'b1, status_only(ST_ILLEGAL));
        add_row(mac_word(OP_UMULL, 1'b1, 4'd9, 4'd1, 4'd2, 4'd9), 32'd2, 32'd3, 32'd0, 32'd0,
                1'b1, status_only(ST_ILLEGAL));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            send_item(dir_rows[k].word, dir_rows[k].rm_v, dir_rows[k].rs_v, dir_rows[k].rn_v,
                      dir_rows[k].rd_v, dir_rows[k].typed ? dir_rows[k].want :
                      mac_compute(dir_rows[k].word, dir_rows[k].rm_v, dir_rows[k].rs_v,
                                  dir_rows[k].rn_v, dir_rows[k].rd_v));
        end

        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n % 64 == 0) begin
                tx_odds = $urandom_range(0, 3) * 10;
            end
            if (n == RANDOM_OPS - CALM_TAIL) begin
                quiet = 1'b1;
            end
            word = random_word();
            rm_v = pick_operand();
            rs_v = pick_operand();
            rn_v = pick_operand();
            rd_v = pick_operand();
            send_item(word, rm_v, rs_v, rn_v, rd_v, mac_compute(word, rm_v, rs_v, rn_v, rd_v));
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("multiply_accumulate_execute: match");
        end else begin
            $display("multiply_accumulate_execute: mismatch");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/core/mae_pkg.sv
rtl/core/mae_front.sv
rtl/core/mae_queue.sv
rtl/core/mae_back.sv
rtl/core/multiply_accumulate_execute.sv
tb/tb_multiply_accumulate_execute.sv
